// File: hdl/tdm_pkg.sv
`timescale 1ns / 1ps

package tdm_pkg;

  // field widths
  localparam int STATE_W = 8;
  localparam int SYM_W   = 7;

  // default sizes of the automaton stores
  localparam int STATE_COUNT_DEF  = 256;
  localparam int SYMBOL_COUNT_DEF = 128;

  // start register value after reset
  localparam logic [STATE_W-1:0] START_RESET = 8'd1;

  // dead state
  localparam logic [STATE_W-1:0] DEAD_STATE = 8'd0;

  // item actions
  typedef enum logic [1:0] {
    ACT_WR_TRANS = 2'd0,
    ACT_WR_FLAG  = 2'd1,
    ACT_TEXT     = 2'd2,
    ACT_EOS      = 2'd3
  } tdm_action_t;

endpackage

// File: hdl/tdm_if.sv
`timescale 1ns / 1ps

// input word channel
interface tdm_in_if;
  logic                         valid;
  logic                         ready;
  tdm_pkg::tdm_action_t         action;
  logic [tdm_pkg::STATE_W-1:0]  entry_state;
  logic [tdm_pkg::SYM_W-1:0]    entry_symbol;
  logic [tdm_pkg::STATE_W-1:0]  entry_next;
  logic                         accept_value;
  logic [tdm_pkg::SYM_W-1:0]    text_byte;

  modport source (output valid, action, entry_state, entry_symbol, entry_next,
                  accept_value, text_byte, input ready);
  modport sink   (input valid, action, entry_state, entry_symbol, entry_next,
                  accept_value, text_byte, output ready);
endinterface

// result word channel
interface tdm_out_if;
  logic                         valid;
  logic                         ready;
  logic                         matched;
  logic [tdm_pkg::STATE_W-1:0]  final_state;

  modport source (output valid, matched, final_state, input ready);
  modport sink   (input valid, matched, final_state, output ready);
endinterface

// start register write channel
interface tdm_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [tdm_pkg::STATE_W-1:0]  start_state;

  modport source (output valid, start_state, input ready);
  modport sink   (input valid, start_state, output ready);
endinterface

// File: hdl/tdm_ram.sv
`timescale 1ns / 1ps

module tdm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read that holds when not enabled
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/table_driven_dfa_matcher.sv
`timescale 1ns / 1ps

// channel  | dir | handshake          | payload
// ---------+-----+--------------------+---------------------------------------------
// cfg_ch   | in  | valid/ready        | start_state
// in_ch    | in  | valid/ready        | action, entry_state, entry_symbol,
//          |     |                    | entry_next, accept_value, text_byte
// out_ch   | out | valid/ready        | matched, final_state
//
// One input word per cycle while in_ch.ready is high. A text byte reads the
// transition memory once; the next byte's read address is forwarded from that
// memory's read data. End of string reads the flag memory; its result passes
// the flag read stage, then the output register. After reset a clearing pass
// zeroes all STATE_COUNT * 2**clog2(SYMBOL_COUNT) transition entries (32768 by
// default) and the flag memory, with in_ch.ready low. After it, in_ch stalls
// only when a result waits in both the flag read stage and the output register.

module table_driven_dfa_matcher #(
  parameter int STATE_COUNT  = tdm_pkg::STATE_COUNT_DEF,
  parameter int SYMBOL_COUNT = tdm_pkg::SYMBOL_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tdm_cfg_if.sink   cfg_ch,
  tdm_in_if.sink    in_ch,
  tdm_out_if.source out_ch
);

  localparam int STW    = $clog2(STATE_COUNT);
  localparam int SYW    = $clog2(SYMBOL_COUNT);
  localparam int AW     = STW + SYW;
  localparam int TDEPTH = STATE_COUNT * (1 << SYW);

  localparam int SW = tdm_pkg::STATE_W;

  // start register
  logic [SW-1:0] start_r;

  // clearing pass
  logic          clr_busy_r;
  logic [AW-1:0] clr_cnt_r;

  // current state and forwarding from the transition read
  logic [SW-1:0] cur_r;
  logic          pend_r;
  logic          pend_dead_r;
  logic [SW-1:0] cur;

  // flag read stage
  logic          eos_s1_r;
  logic          s1_ok_r;
  logic [SW-1:0] s1_state_r;

  // output register
  logic          out_valid_r;
  logic          matched_r;
  logic [SW-1:0] final_state_r;

  // memory ports
  logic          t_we, t_re, f_we, f_re;
  logic [AW-1:0] t_waddr, t_raddr;
  logic [SW-1:0] t_wdata, t_rdata;
  logic [STW-1:0] f_waddr, f_raddr;
  logic          f_wdata, f_rdata;

  // widened fields for index extraction
  logic [15:0] cur_w, est_w;
  logic [15:0] esym_w, tbyte_w;

  logic in_acc, s1_stall, out_free;
  logic est_ok, esym_ok, tbyte_ok, cur_ok;

  assign cfg_ch.ready = 1'b1;

  assign s1_stall    = eos_s1_r && out_valid_r && !out_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !clr_busy_r && !s1_stall;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // forwarded current state
  always_comb begin
    if (pend_r) begin
      cur = pend_dead_r ? tdm_pkg::DEAD_STATE : t_rdata;
    end else begin
      cur = cur_r;
    end
  end

  assign cur_w   = 16'(cur);
  assign est_w   = 16'(in_ch.entry_state);
  assign esym_w  = 16'(in_ch.entry_symbol);
  assign tbyte_w = 16'(in_ch.text_byte);

  assign est_ok   = 32'(in_ch.entry_state) < STATE_COUNT;
  assign esym_ok  = 32'(in_ch.entry_symbol) < SYMBOL_COUNT;
  assign tbyte_ok = 32'(in_ch.text_byte) < SYMBOL_COUNT;
  assign cur_ok   = (cur != tdm_pkg::DEAD_STATE) && (32'(cur) < STATE_COUNT);

  // memory port control
  always_comb begin
    t_we    = 1'b0;
    t_waddr = {est_w[STW-1:0], esym_w[SYW-1:0]};
    t_wdata = in_ch.entry_next;
    t_re    = 1'b0;
    t_raddr = {cur_w[STW-1:0], tbyte_w[SYW-1:0]};
    f_we    = 1'b0;
    f_waddr = est_w[STW-1:0];
    f_wdata = in_ch.accept_value;
    f_re    = 1'b0;
    f_raddr = cur_w[STW-1:0];
    if (clr_busy_r) begin
      t_we    = 1'b1;
      t_waddr = clr_cnt_r;
      t_wdata = tdm_pkg::DEAD_STATE;
      f_we    = 1'b1;
      f_waddr = clr_cnt_r[AW-1:SYW];
      f_wdata = 1'b0;
    end else if (in_acc) begin
      case (in_ch.action)
        tdm_pkg::ACT_WR_TRANS: t_we = est_ok && esym_ok;
        tdm_pkg::ACT_WR_FLAG:  f_we = est_ok;
        tdm_pkg::ACT_TEXT:     t_re = 1'b1;
        tdm_pkg::ACT_EOS:      f_re = 1'b1;
        default:               t_we = 1'b0;
      endcase
    end
  end

  tdm_ram #(.WIDTH(SW), .DEPTH(TDEPTH)) u_trans_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .re    (t_re),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  tdm_ram #(.WIDTH(1), .DEPTH(STATE_COUNT)) u_flag_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .re    (f_re),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  // start register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= tdm_pkg::START_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      start_r <= cfg_ch.start_state;
    end
  end

  // clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
      if (clr_cnt_r == AW'(TDEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // current state tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= tdm_pkg::START_RESET;
      pend_r <= 1'b0;
    end else begin
      pend_r <= in_acc && (in_ch.action == tdm_pkg::ACT_TEXT);
      if (in_acc && (in_ch.action == tdm_pkg::ACT_EOS)) begin
        cur_r <= start_r;
      end else begin
        cur_r <= cur;
      end
    end
  end

  // dead marker for the pending transition read
  always_ff @(posedge clk) begin
    pend_dead_r <= !cur_ok || !tbyte_ok;
  end

  // flag read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eos_s1_r <= 1'b0;
    end else if (!s1_stall) begin
      eos_s1_r <= in_acc && (in_ch.action == tdm_pkg::ACT_EOS);
    end
  end

  always_ff @(posedge clk) begin
    if (!s1_stall) begin
      s1_ok_r    <= cur_ok;
      s1_state_r <= cur;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= eos_s1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      matched_r     <= s1_ok_r && f_rdata;
      final_state_r <= s1_state_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.matched     = matched_r;
  assign out_ch.final_state = final_state_r;

`ifndef SYNTHESIS
  // an accepted end of string enters the flag read stage
  a_eos_enters_s1 : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.action == tdm_pkg::ACT_EOS) |=> eos_s1_r)
    else $error("end of string lost before flag read stage");

  // flag read data holds while its result is stalled
  a_flag_hold : assert property (@(posedge clk) disable iff (!rst_n)
    s1_stall |=> $stable(f_rdata))
    else $error("flag read data changed under stall");

  // a result in the flag stage moves to the output when it can
  a_s1_to_out : assert property (@(posedge clk) disable iff (!rst_n)
    (eos_s1_r && !s1_stall) |=> out_valid_r)
    else $error("result dropped between flag stage and output");

  // no word is taken during the clearing pass
  a_no_acc_clear : assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !(in_acc || t_re || f_re))
    else $error("access during clearing pass");

  // a byte in the dead state keeps the state dead
  a_dead_sticks : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.action == tdm_pkg::ACT_TEXT && cur == tdm_pkg::DEAD_STATE)
      |=> (pend_r && pend_dead_r))
    else $error("dead state left on text byte");
`endif

endmodule
